// ===== design/scma_pkg.sv =====
`timescale 1ns / 1ps

package scma_pkg;

    // Field widths fixed by the pixel and result formats
    localparam int PROB_W   = 16;
    localparam int CLASS_W  = 3;
    localparam int NCLS_W   = 4;
    localparam int SUM_W    = 36;
    localparam int NUM_PROB = 8;

    // Class count after reset
    localparam logic [NCLS_W-1:0] NCLS_RST = 4'd8;

    typedef struct packed {
        logic [CLASS_W-1:0] label;
        logic [PROB_W-1:0]  prob_0;
        logic [PROB_W-1:0]  prob_1;
        logic [PROB_W-1:0]  prob_2;
        logic [PROB_W-1:0]  prob_3;
        logic [PROB_W-1:0]  prob_4;
        logic [PROB_W-1:0]  prob_5;
        logic [PROB_W-1:0]  prob_6;
        logic [PROB_W-1:0]  prob_7;
        logic               last_pixel;
    } t_pixel;

    typedef struct packed {
        logic [CLASS_W-1:0] pred_class;
        logic [CLASS_W-1:0] true_class;
        logic [SUM_W-1:0]   score_sum;
        logic               last_entry;
    } t_result;

    // Travels with a dump read towards the merge stage
    typedef struct packed {
        logic               vld;
        logic [CLASS_W-1:0] row;
        logic [CLASS_W-1:0] col;
        logic               last;
    } t_dump_meta;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_DUMP
    } t_state;

    // Probability of one predicted class out of a pixel
    function automatic logic [PROB_W-1:0] pixel_prob(input t_pixel px, input int idx);
        logic [PROB_W-1:0] v;
        case (idx)
            0: v = px.prob_0;
            1: v = px.prob_1;
            2: v = px.prob_2;
            3: v = px.prob_3;
            4: v = px.prob_4;
            5: v = px.prob_5;
            6: v = px.prob_6;
            7: v = px.prob_7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/scma_lane.sv =====
`timescale 1ns / 1ps

// One matrix row: entries for every true class of one predicted class
module scma_lane import scma_pkg::*; #(
    parameter int DEPTH    = 8,
    parameter int IDX_W    = 3,
    parameter int ACC_BITS = 36
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc_en,
    input  logic [IDX_W-1:0]    i_rd_addr,
    input  logic [PROB_W-1:0]   i_prob,
    input  logic                i_clear,
    output logic [ACC_BITS-1:0] o_word
);

    logic [ACC_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]    r_valid;

    logic [ACC_BITS-1:0] r_rd_data;
    logic                r_rd_vld;
    logic                r_s1_vld;
    logic [IDX_W-1:0]    r_s1_addr;
    logic [PROB_W-1:0]   r_s1_prob;
    logic                r_byp_hit;
    logic [ACC_BITS-1:0] r_byp_data;

    logic [ACC_BITS-1:0] n_old;
    logic [ACC_BITS:0]   n_sum;
    logic [ACC_BITS-1:0] n_sat;

    // Current entry value: forwarded write, stored word, or zero if never written
    always_comb begin
        if (r_byp_hit) begin
            n_old = r_byp_data;
        end else if (r_rd_vld) begin
            n_old = r_rd_data;
        end else begin
            n_old = '0;
        end
        n_sum = {1'b0, n_old} + {{(ACC_BITS + 1 - PROB_W){1'b0}}, r_s1_prob};
        n_sat = n_sum[ACC_BITS] ? {ACC_BITS{1'b1}} : n_sum[ACC_BITS-1:0];
    end

    assign o_word = n_old;

    // Storage: one read and one write port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
        if (r_s1_vld) begin
            r_mem[r_s1_addr] <= n_sat;
        end
    end

    // Entry valid bits, cleared all at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[i_rd_addr];
            if (i_clear) begin
                r_valid <= '0;
            end else if (r_s1_vld) begin
                r_valid[r_s1_addr] <= 1'b1;
            end
        end
    end

    // Add stage and write forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_byp_hit <= 1'b0;
        end else begin
            r_s1_vld  <= i_acc_en;
            r_byp_hit <= r_s1_vld && (r_s1_addr == i_rd_addr);
        end
        r_s1_addr  <= i_rd_addr;
        r_s1_prob  <= i_prob;
        r_byp_data <= n_sat;
    end

endmodule

// ===== design/scma_merge.sv =====
`timescale 1ns / 1ps

// Picks the row being dumped out of the lane words and registers the result
module scma_merge import scma_pkg::*; #(
    parameter int LANES    = 8,
    parameter int IDX_W    = 3,
    parameter int ACC_BITS = 36
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [LANES-1:0][ACC_BITS-1:0]   i_words,
    input  t_dump_meta                       i_meta,
    output logic                             o_valid,
    output t_result                          o_result
);

    logic [ACC_BITS-1:0]       n_word;
    logic [SUM_W+ACC_BITS-1:0] n_wide;
    t_result                   r_result;
    logic                      r_valid;

    always_comb begin
        n_word = i_words[i_meta.row[IDX_W-1:0]];
        n_wide = {{SUM_W{1'b0}}, n_word};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_meta.vld;
        end
        r_result.pred_class <= i_meta.row;
        r_result.true_class <= i_meta.col;
        r_result.score_sum  <= n_wide[SUM_W-1:0];
        r_result.last_entry <= i_meta.last;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== design/soft_confusion_matrix_accumulator.sv =====
`timescale 1ns / 1ps
// Throughput: one pixel per cycle; busy rises only for the end-of-image dump.
// A pixel's probabilities pass through the registered add stage before the store.
// A last pixel holds busy through the drain state and the n*n dump reads; the n*n
// results strobe one per cycle, row by row, via the dump meta and merge registers.
// The receiver cannot stall. Synchronous reset empties the matrix at once
// (per-entry valid bits) and sets the class count to 8.
module soft_confusion_matrix_accumulator import scma_pkg::*; #(
    parameter int MAX_CLASSES = 8,
    parameter int ACC_BITS    = 36
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_pixel            i_pixel,
    input  logic              i_cfg_we,
    input  logic [NCLS_W-1:0] i_cfg_data,
    output logic              o_valid,
    output t_result           o_result
);

    localparam int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam logic [NCLS_W-1:0] NCLS_MAX = NCLS_W'(MAX_CLASSES);

    logic [NCLS_W-1:0] r_num_classes;
    t_state            r_state, n_state;
    logic [CLASS_W-1:0] r_row, n_row;
    logic [CLASS_W-1:0] r_col, n_col;
    t_dump_meta        r_meta, n_meta;
    logic              n_clear;

    logic [NCLS_W-1:0]  n_act;
    logic [CLASS_W-1:0] n_top;
    logic               w_accept;
    logic               w_label_ok;
    logic [IDX_W-1:0]   w_rd_addr;
    logic [MAX_CLASSES-1:0]               w_acc_en;
    logic [MAX_CLASSES-1:0][ACC_BITS-1:0] w_words;

    // Class count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_classes <= NCLS_RST;
        end else if (i_cfg_we) begin
            r_num_classes <= i_cfg_data;
        end
    end

    // Active class count, clamped to 1..MAX_CLASSES
    always_comb begin
        if (r_num_classes == '0) begin
            n_act = NCLS_W'(1);
        end else if (r_num_classes > NCLS_MAX) begin
            n_act = NCLS_MAX;
        end else begin
            n_act = r_num_classes;
        end
        n_top = CLASS_W'(n_act - NCLS_W'(1));
    end

    assign busy       = (r_state != ST_IDLE);
    assign w_accept   = start && !busy;
    assign w_label_ok = ({1'b0, i_pixel.label} < n_act);
    assign w_rd_addr  = (r_state == ST_DUMP) ? r_col[IDX_W-1:0] : i_pixel.label[IDX_W-1:0];

    // One lane per predicted class
    for (genvar g = 0; g < MAX_CLASSES; g++) begin : g_lane
        assign w_acc_en[g] = w_accept && w_label_ok && (NCLS_W'(g) < n_act);

        scma_lane #(
            .DEPTH    (MAX_CLASSES),
            .IDX_W    (IDX_W),
            .ACC_BITS (ACC_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_acc_en  (w_acc_en[g]),
            .i_rd_addr (w_rd_addr),
            .i_prob    (pixel_prob(i_pixel, g)),
            .i_clear   (n_clear),
            .o_word    (w_words[g])
        );
    end

    // Dump sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_row      <= '0;
            r_col      <= '0;
            r_meta.vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_col      <= n_col;
            r_meta.vld <= n_meta.vld;
        end
        r_meta.row  <= n_meta.row;
        r_meta.col  <= n_meta.col;
        r_meta.last <= n_meta.last;
    end

    // Next state: drain the add stage, then walk the n by n square row by row
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_clear     = 1'b0;
        n_meta.vld  = 1'b0;
        n_meta.row  = r_row;
        n_meta.col  = r_col;
        n_meta.last = (r_row == n_top) && (r_col == n_top);
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_pixel.last_pixel) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_row   = '0;
                n_col   = '0;
                n_state = ST_DUMP;
            end
            ST_DUMP: begin
                n_meta.vld = 1'b1;
                if (r_col == n_top) begin
                    n_col = '0;
                    n_row = r_row + CLASS_W'(1);
                    if (r_row == n_top) begin
                        n_clear = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_col = r_col + CLASS_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    scma_merge #(
        .LANES    (MAX_CLASSES),
        .IDX_W    (IDX_W),
        .ACC_BITS (ACC_BITS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_words  (w_words),
        .i_meta   (r_meta),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // A last pixel always starts a dump
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_pixel.last_pixel) |=> busy)
        else $error("last pixel transfer did not start a dump");

    // Every dump read becomes a result transfer in the next cycle
    a_meta_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_meta.vld |=> o_valid)
        else $error("dump read lost before output");

    // The final entry sits on the diagonal
    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last_entry) |-> (o_result.pred_class == o_result.true_class))
        else $error("final entry off the diagonal");

    // No accumulation while the store is being read out
    a_no_acc_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> (w_acc_en == '0))
        else $error("accumulate during dump");

endmodule
